// ===== design/separable_conv2d_3x3_top_assert.svh =====
// ----------------------------------------------------------------------------
// separable_conv2d_3x3_top_assert.svh
// Assertion macros for the separable 3x3 convolution block.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_CONV2D_3X3_TOP_ASSERT_SVH
`define SEPARABLE_CONV2D_3X3_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SEPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SEPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SEPC_ASSERT_IMP(lbl, ante, cons, msg)
`define SEPC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/sepc_pkg.sv =====
// ----------------------------------------------------------------------------
// sepc_pkg
// Shared widths, register indexes and bundles of the separable 3x3 filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sepc_pkg;

    localparam int KERNEL_SIZE   = 3;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int VPROD_W   = COEF_W + PIX_W + 1;
    localparam int VSUM_W    = 27;
    localparam int HPROD_W   = COEF_W + VSUM_W;
    localparam int HSUM_W    = HPROD_W + 2;
    localparam int OUT_SHIFT = 20;
    localparam int OUT_W     = 24;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEF_V0      = 3'd0,
        REG_COEF_V1      = 3'd1,
        REG_COEF_V2      = 3'd2,
        REG_COEF_H0      = 3'd3,
        REG_COEF_H1      = 3'd4,
        REG_COEF_H2      = 3'd5,
        REG_LINE_WIDTH   = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] v0;
        logic signed [COEF_W-1:0] v1;
        logic signed [COEF_W-1:0] v2;
        logic signed [COEF_W-1:0] h0;
        logic signed [COEF_W-1:0] h1;
        logic signed [COEF_W-1:0] h2;
    } coefs_t;

    typedef struct packed {
        logic vmul_en;
        logic vsum_en;
        logic hmul_en;
    } filt_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sepc_line_store.sv =====
// ----------------------------------------------------------------------------
// sepc_line_store
// One-port-read, one-port-write line memory holding the two previous rows.
// ----------------------------------------------------------------------------
`default_nettype none

module sepc_line_store import sepc_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [2*PIX_W-1:0]         rd_data,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [2*PIX_W-1:0]         wr_data
);

    // High byte is row r-2, low byte is row r-1.
    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/sepc_filter.sv =====
// ----------------------------------------------------------------------------
// sepc_filter
// Vertical and horizontal multiply-add stages, column sums, rounding and
// saturation of the filter result.
// ----------------------------------------------------------------------------
`default_nettype none

module sepc_filter import sepc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire filt_ctrl_t               ctrl,
    input  wire coefs_t                   coefs,
    input  wire logic [2*PIX_W-1:0]       up_data,
    input  wire logic [PIX_W-1:0]         pixel,
    output logic signed [OUT_W-1:0]       result
);

    logic signed [VPROD_W-1:0] vprod0_reg, vprod1_reg, vprod2_reg;
    logic signed [VSUM_W-1:0]  col0_reg, col1_reg, col2_reg;
    logic signed [HPROD_W-1:0] hprod0_reg, hprod1_reg, hprod2_reg;
    logic signed [VSUM_W-1:0]  vsum;
    logic signed [HSUM_W-1:0]  hsum;
    logic signed [HSUM_W-1:0]  rounded;
    logic [HSUM_W-OUT_SHIFT-1:0] scaled;

    always_ff @(posedge aclk) begin
        if (ctrl.vmul_en) begin
            vprod0_reg <= coefs.v0 * $signed({1'b0, up_data[2*PIX_W-1:PIX_W]});
            vprod1_reg <= coefs.v1 * $signed({1'b0, up_data[PIX_W-1:0]});
            vprod2_reg <= coefs.v2 * $signed({1'b0, pixel});
        end
    end

    assign vsum = VSUM_W'(vprod0_reg) + VSUM_W'(vprod1_reg) + VSUM_W'(vprod2_reg);

    // Shift line of the last three column sums, oldest in col0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col0_reg <= '0;
            col1_reg <= '0;
            col2_reg <= '0;
        end else if (ctrl.vsum_en) begin
            col0_reg <= col1_reg;
            col1_reg <= col2_reg;
            col2_reg <= vsum;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.hmul_en) begin
            hprod0_reg <= coefs.h0 * col0_reg;
            hprod1_reg <= coefs.h1 * col1_reg;
            hprod2_reg <= coefs.h2 * col2_reg;
        end
    end

    // Round half up from 28 to 8 fraction bits, then clamp to 24 bits.
    assign hsum    = HSUM_W'(hprod0_reg) + HSUM_W'(hprod1_reg) + HSUM_W'(hprod2_reg);
    assign rounded = hsum + (HSUM_W'(1) <<< (OUT_SHIFT - 1));
    assign scaled  = rounded[HSUM_W-1:OUT_SHIFT];

    always_comb begin
        if (scaled[HSUM_W-OUT_SHIFT-1] != scaled[OUT_W-1]) begin
            result = scaled[HSUM_W-OUT_SHIFT-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            result = scaled[OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/separable_conv2d_3x3_top.sv =====
// ----------------------------------------------------------------------------
// separable_conv2d_3x3_top
// Streaming separable 3x3 convolution of grey pixels with line memory.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata                 tuser         tlast
// s_*       in         pixel[7:0]            frame_start   -
// m_*       out        value[23:0]           frame_last    row_last
// cfg_*     in         coefficient/size write, index in cfg_addr
//
// An item whose window touches the border goes through the read and column-sum
// states, one that gives a result also the horizontal multiply and sum states, set
// by the memory read-modify-write and registered vertical and horizontal multiplies.
// A result that m_tready holds back stalls the last stage until it is taken.
// Reset (aresetn low, synchronous) clears the counters, column sums, control
// and configuration registers; the line memory and data registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_conv2d_3x3_top import sepc_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
    input  wire logic                  s_tuser,   // [0] frame_start
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // [23:0] value
    output logic                       m_tlast,   // row_last
    output logic                       m_tuser,   // [0] frame_last
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "separable_conv2d_3x3_top_assert.svh"

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > $clog2(MAX_WIDTH + 1)) ? COL_W + 1
                                                               : $clog2(MAX_WIDTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_VSUM = 5'b00100,
        ST_HMUL = 5'b01000,
        ST_HSUM = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    coefs_t            coefs_reg;
    logic [COL_W-1:0]  line_width_reg;
    logic [ROW_W-1:0]  frame_height_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic [PIX_W-1:0]  px_reg;
    logic [AW-1:0]     addr_reg;
    logic              win_reg, row_end_reg, frame_end_reg;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg, m_tuser_reg;

    logic              accept;
    logic              out_free;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [CMP_W-1:0]  w_eff, col_inc;
    logic [ROW_W:0]    h_eff, row_inc;
    logic              row_end, frame_end, win;
    logic [AW-1:0]     rd_addr;
    logic [2*PIX_W-1:0] up_data;
    filt_ctrl_t        fctrl;
    logic signed [OUT_W-1:0] result;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.v0     <= '0;
            coefs_reg.v1     <= COEF_W'(16384);
            coefs_reg.v2     <= '0;
            coefs_reg.h0     <= '0;
            coefs_reg.h1     <= COEF_W'(16384);
            coefs_reg.h2     <= '0;
            line_width_reg   <= COL_W'(1024);
            frame_height_reg <= ROW_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_COEF_V0:      coefs_reg.v0     <= cfg_wdata;
                REG_COEF_V1:      coefs_reg.v1     <= cfg_wdata;
                REG_COEF_V2:      coefs_reg.v2     <= cfg_wdata;
                REG_COEF_H0:      coefs_reg.h0     <= cfg_wdata;
                REG_COEF_H1:      coefs_reg.h1     <= cfg_wdata;
                REG_COEF_H2:      coefs_reg.h2     <= cfg_wdata;
                REG_LINE_WIDTH:   line_width_reg   <= cfg_wdata[COL_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position tracking at the accepted item
    // ------------------------------------------------------------------
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign col_cur = s_tuser ? '0 : col_reg;
    assign row_cur = s_tuser ? '0 : row_reg;

    always_comb begin
        if (line_width_reg < COL_W'(KERNEL_SIZE)) begin
            w_eff = CMP_W'(KERNEL_SIZE);
        end else if (CMP_W'(line_width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(line_width_reg);
        end
        if (frame_height_reg < ROW_W'(KERNEL_SIZE)) begin
            h_eff = (ROW_W+1)'(KERNEL_SIZE);
        end else begin
            h_eff = {1'b0, frame_height_reg};
        end
    end

    assign col_inc   = CMP_W'(col_cur) + CMP_W'(1);
    assign row_inc   = {1'b0, row_cur} + (ROW_W+1)'(1);
    assign row_end   = (col_inc >= w_eff);
    assign frame_end = row_end && (row_inc >= h_eff);
    assign win       = (col_cur >= COL_W'(KERNEL_SIZE - 1))
                    && (row_cur >= ROW_W'(KERNEL_SIZE - 1));

    // A column past the memory depth (after the width shrank) maps to the last entry.
    assign rd_addr = (CMP_W'(col_cur) > CMP_W'(MAX_WIDTH - 1)) ? AW'(MAX_WIDTH - 1)
                                                               : AW'(col_cur);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg        <= s_tdata;
            addr_reg      <= rd_addr;
            win_reg       <= win;
            row_end_reg   <= row_end;
            frame_end_reg <= frame_end;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)   state_next = ST_READ;
            ST_READ:               state_next = ST_VSUM;
            ST_VSUM:               state_next = win_reg ? ST_HMUL : ST_IDLE;
            ST_HMUL:               state_next = ST_HSUM;
            ST_HSUM: if (out_free) state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign fctrl.vmul_en = (state_reg == ST_READ);
    assign fctrl.vsum_en = (state_reg == ST_VSUM);
    assign fctrl.hmul_en = (state_reg == ST_HMUL);

    // ------------------------------------------------------------------
    // Line memory: read on accept, write the shifted entry in the cycle after.
    // The next read of any entry comes after the write, as items are accepted only in idle.
    // ------------------------------------------------------------------
    sepc_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (up_data),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (addr_reg),
        .wr_data ({up_data[PIX_W-1:0], px_reg})
    );

    sepc_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fctrl),
        .coefs   (coefs_reg),
        .up_data (up_data),
        .pixel   (px_reg),
        .result  (result)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_HSUM && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_HSUM && out_free) begin
            m_tdata_reg <= result;
            m_tlast_reg <= row_end_reg;
            m_tuser_reg <= frame_end_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SEPC_ASSERT_IMP(a_out_only_in_window, state_reg == ST_HSUM, win_reg,
        "result stage reached for a border item")
    `SEPC_ASSERT_IMP(a_frame_last_is_row_last, m_tvalid && m_tuser, m_tlast,
        "frame_last without row_last")
    `SEPC_ASSERT_NXT(a_row_wrap, accept && row_end, col_reg == '0,
        "column counter did not wrap at end of row")
    `SEPC_ASSERT_NXT(a_hold_on_stall, state_reg == ST_HSUM && !out_free,
        state_reg == ST_HSUM, "result stage left while output was blocked")

endmodule

`default_nettype wire
